// File: hdl/afis_pkg.sv
// Shared types and constants for the animation frame index selector.
// Used by afis_ctrl, afis_datapath and animation_frame_index_select.
// Depends on nothing else.
package afis_pkg;

  typedef enum logic [1:0] {
    ModeLoop     = 2'd0,
    ModeHold     = 2'd1,
    ModePingPong = 2'd2,
    ModePass     = 2'd3
  } end_mode_e;

  localparam logic [1:0] CfgStartFrame   = 2'd0;
  localparam logic [1:0] CfgPlaybackRate = 2'd1;
  localparam logic [1:0] CfgTextureCount = 2'd2;
  localparam logic [1:0] CfgEndMode      = 2'd3;

  localparam int unsigned RawW      = 31;
  localparam int unsigned RateW     = 24;
  localparam int unsigned RateFracW = 16;
  localparam int unsigned CountW    = 16;
  localparam int unsigned ProdW     = RawW + RateW;
  localparam int unsigned DivSteps  = RawW;
  localparam int unsigned DivCntW   = $clog2(DivSteps);

  localparam logic [RawW-1:0] RawMax = {RawW{1'b1}};

  typedef struct packed {
    logic capture;
    logic mul;
    logic sat;
    logic div_step;
    logic load_out;
  } afis_cmd_t;

  typedef struct packed {
    logic early;
    logic need_div;
    logic out_busy;
  } afis_sts_t;

endpackage

// File: hdl/afis_ctrl.sv
// Controller state machine of the animation frame index selector.
// Sequences capture, multiply, saturate, divide and output load.
// Depends on afis_pkg.
module afis_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  afis_pkg::afis_sts_t sts_i,
  output afis_pkg::afis_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    StIdle,
    StMul,
    StSat,
    StDiv,
    StDone
  } state_e;

  state_e                       state_q;
  logic [afis_pkg::DivCntW-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            state_q <= StMul;
          end
        end
        StMul: begin
          state_q <= StSat;
        end
        StSat: begin
          cnt_q <= '0;
          if (sts_i.need_div && !sts_i.early) begin
            state_q <= StDiv;
          end else begin
            state_q <= StDone;
          end
        end
        StDiv: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == afis_pkg::DivCntW'(afis_pkg::DivSteps - 1)) begin
            state_q <= StDone;
          end
        end
        StDone: begin
          if (!sts_i.out_busy) begin
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign in_stall_o = (state_q != StIdle);

  always_comb begin
    cmd_o          = '0;
    cmd_o.capture  = (state_q == StIdle) && in_valid_i;
    cmd_o.mul      = (state_q == StMul);
    cmd_o.sat      = (state_q == StSat);
    cmd_o.div_step = (state_q == StDiv);
    cmd_o.load_out = (state_q == StDone) && !sts_i.out_busy;
  end

endmodule

// File: hdl/afis_datapath.sv
// Datapath of the animation frame index selector: configuration registers,
// rate multiplier, saturation, bit-serial divider and output register.
// Depends on afis_pkg.
module afis_datapath #(
  parameter int unsigned FRAME_FRAC_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [1:0]                          cfg_index_i,
  input  logic [afis_pkg::RateW-1:0]          cfg_data_i,
  input  logic signed [31:0]                  frame_time_i,
  input  afis_pkg::afis_cmd_t                 cmd_i,
  output afis_pkg::afis_sts_t                 sts_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [afis_pkg::RawW-1:0]           texture_index_o,
  output logic                                play_backward_o
);

  localparam int unsigned StartW = afis_pkg::CountW + FRAME_FRAC_BITS;
  localparam int unsigned CmpW   = (StartW > afis_pkg::RawW) ? StartW : afis_pkg::RawW;
  localparam int unsigned Shift  = FRAME_FRAC_BITS + afis_pkg::RateFracW;

  logic [afis_pkg::CountW-1:0] start_frame_q;
  logic [afis_pkg::RateW-1:0]  playback_rate_q;
  logic [afis_pkg::CountW-1:0] texture_count_q;
  afis_pkg::end_mode_e         end_mode_q;

  logic [afis_pkg::RawW-1:0]   frame_q;
  logic                        early_q;
  logic [afis_pkg::ProdW-1:0]  product_q;
  logic [afis_pkg::RawW-1:0]   raw_q;
  logic [afis_pkg::CountW-1:0] rem_q;
  logic [afis_pkg::RawW-1:0]   quo_q;
  logic                        dir_q;
  logic                        out_valid_q;
  logic [afis_pkg::RawW-1:0]   index_q;

  logic [StartW-1:0]           start_fx;
  logic                        after_start;
  logic                        early_d;
  logic [afis_pkg::ProdW-1:0]  product_d;
  logic [afis_pkg::ProdW-1:0]  shifted;
  logic [afis_pkg::RawW-1:0]   raw_d;
  logic [afis_pkg::CountW:0]   trial;
  logic                        trial_ge;
  logic [afis_pkg::CountW-1:0] rem_d;
  logic [afis_pkg::CountW-1:0] mirror;
  logic [afis_pkg::RawW-1:0]   index_d;
  logic                        dir_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_frame_q   <= '0;
      playback_rate_q <= afis_pkg::RateW'(65536);
      texture_count_q <= afis_pkg::CountW'(1);
      end_mode_q      <= afis_pkg::ModeLoop;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        afis_pkg::CfgStartFrame: begin
          start_frame_q <= cfg_data_i[afis_pkg::CountW-1:0];
        end
        afis_pkg::CfgPlaybackRate: begin
          playback_rate_q <= cfg_data_i;
        end
        afis_pkg::CfgTextureCount: begin
          texture_count_q <= cfg_data_i[afis_pkg::CountW-1:0];
        end
        afis_pkg::CfgEndMode: begin
          end_mode_q <= afis_pkg::end_mode_e'(cfg_data_i[1:0]);
        end
        default: begin
        end
      endcase
    end
  end

  assign start_fx    = StartW'(start_frame_q) << FRAME_FRAC_BITS;
  assign after_start = !frame_time_i[31]
                       && (CmpW'(frame_time_i[afis_pkg::RawW-1:0]) > CmpW'(start_fx));
  assign early_d     = !after_start || (texture_count_q <= afis_pkg::CountW'(1));

  assign product_d = {{afis_pkg::RateW{1'b0}}, frame_q}
                     * {{afis_pkg::RawW{1'b0}}, playback_rate_q};
  assign shifted   = product_q >> Shift;
  assign raw_d     = (|shifted[afis_pkg::ProdW-1:afis_pkg::RawW]) ? afis_pkg::RawMax
                                                                 : shifted[afis_pkg::RawW-1:0];

  assign trial    = {rem_q, quo_q[afis_pkg::RawW-1]};
  assign trial_ge = trial >= {1'b0, texture_count_q};
  assign rem_d    = trial_ge ? afis_pkg::CountW'(trial - {1'b0, texture_count_q})
                             : trial[afis_pkg::CountW-1:0];

  assign mirror = texture_count_q - rem_q - afis_pkg::CountW'(1);

  always_comb begin
    dir_d   = dir_q;
    index_d = '0;
    if (!early_q) begin
      case (end_mode_q)
        afis_pkg::ModeLoop: begin
          index_d = afis_pkg::RawW'(rem_q);
        end
        afis_pkg::ModeHold: begin
          if (raw_q >= afis_pkg::RawW'(texture_count_q)) begin
            index_d = afis_pkg::RawW'(texture_count_q - afis_pkg::CountW'(1));
          end else begin
            index_d = raw_q;
          end
        end
        afis_pkg::ModePingPong: begin
          dir_d   = quo_q[0];
          index_d = quo_q[0] ? afis_pkg::RawW'(mirror) : afis_pkg::RawW'(rem_q);
        end
        default: begin
          index_d = raw_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      frame_q <= frame_time_i[afis_pkg::RawW-1:0];
      early_q <= early_d;
    end
    if (cmd_i.mul) begin
      product_q <= product_d;
    end
    if (cmd_i.sat) begin
      raw_q <= raw_d;
      quo_q <= raw_d;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      quo_q <= {quo_q[afis_pkg::RawW-2:0], trial_ge};
      rem_q <= rem_d;
    end
    if (cmd_i.load_out) begin
      index_q <= index_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q       <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= cmd_i.load_out || (out_valid_q && out_stall_i);
      if (cmd_i.load_out) begin
        dir_q <= dir_d;
      end
    end
  end

  assign sts_o.early    = early_q;
  assign sts_o.need_div = (end_mode_q == afis_pkg::ModeLoop)
                          || (end_mode_q == afis_pkg::ModePingPong);
  assign sts_o.out_busy = out_valid_q && out_stall_i;

  assign out_valid_o     = out_valid_q;
  assign texture_index_o = index_q;
  assign play_backward_o = dir_q;

endmodule

// File: hdl/animation_frame_index_select.sv
// Animation frame index selector, top level. Depends on afis_pkg, afis_ctrl, afis_datapath.
// Loop and ping-pong modes pass each item through the 31-step bit-serial divider; hold, pass
// and early-exit cases skip it. A new frame time is accepted only once the previous result
// has been loaded into the output register.
// The output register frees the input side while a result waits to be taken.
// Reset: configuration returns to its defaults, direction to backward, no result pending.
module animation_frame_index_select #(
  parameter int unsigned FRAME_FRAC_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_index_i,
  input  logic [afis_pkg::RateW-1:0] cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [31:0]         frame_time_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [afis_pkg::RawW-1:0]  texture_index_o,
  output logic                       play_backward_o
);

  afis_pkg::afis_cmd_t cmd;
  afis_pkg::afis_sts_t sts;

  afis_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  afis_datapath #(
    .FRAME_FRAC_BITS (FRAME_FRAC_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .frame_time_i    (frame_time_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .texture_index_o (texture_index_o),
    .play_backward_o (play_backward_o)
  );

endmodule

// File: bench/frame_index_checker.sv
`timescale 1ns / 100ps
// Checker for the animation frame index selector: tracks register writes, predicts the
// texture index and direction of every accepted item and compares accepted results in order.
// Depends on afis_pkg for the register indexes, end modes and field widths.
module frame_index_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_index_i,
  input  logic [afis_pkg::RateW-1:0]   cfg_data_i,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic signed [31:0]           frame_time_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic [afis_pkg::RawW-1:0]    texture_index_i,
  input  logic                         play_backward_i,
  output int unsigned                  mismatch_count_o,
  output int unsigned                  pending_o
);

  typedef struct packed {
    logic [afis_pkg::RawW-1:0] index;
    logic                      backward;
  } selection_t;

  logic [15:0]                   start_frame_q;
  logic [afis_pkg::RateW-1:0]    rate_q;
  logic [afis_pkg::CountW-1:0]   count_q;
  afis_pkg::end_mode_e           mode_q;
  logic                          backward_q;
  selection_t                    expected_selections[$];

  assign pending_o = expected_selections.size();

  function automatic selection_t select_texture(input logic signed [31:0] frame);
    longint                    frame_fx;
    longint                    start_fx;
    longint                    raw_wide;
    logic [afis_pkg::RawW-1:0] raw;
    logic [afis_pkg::RawW-1:0] quot;
    logic [afis_pkg::RawW-1:0] rem;
    logic [afis_pkg::RawW-1:0] idx;
    logic [afis_pkg::RawW-1:0] cnt;
    selection_t                sel;
    frame_fx = frame;
    start_fx = longint'({start_frame_q, 16'h0000});
    cnt = afis_pkg::RawW'(count_q);
    if (frame_fx <= start_fx || count_q <= 1) begin
      idx = '0;
    end else begin
      raw_wide = (frame_fx * longint'(rate_q)) >>> 32;
      raw = (raw_wide > 64'sh7fff_ffff) ? afis_pkg::RawMax : raw_wide[afis_pkg::RawW-1:0];
      quot = raw / cnt;
      rem = raw % cnt;
      case (mode_q)
        afis_pkg::ModeLoop: begin
          idx = rem;
        end
        afis_pkg::ModeHold: begin
          idx = (raw >= cnt) ? cnt - afis_pkg::RawW'(1) : raw;
        end
        afis_pkg::ModePingPong: begin
          backward_q = quot[0];
          idx = backward_q ? cnt - rem - afis_pkg::RawW'(1) : rem;
        end
        default: begin
          idx = raw;
        end
      endcase
    end
    sel.index = idx;
    sel.backward = backward_q;
    return sel;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    selection_t want;
    if (!rst_ni) begin
      start_frame_q = '0;
      rate_q = 24'd65536;
      count_q = 16'd1;
      mode_q = afis_pkg::ModeLoop;
      backward_q = 1'b1;
      expected_selections.delete();
      mismatch_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          afis_pkg::CfgStartFrame:   start_frame_q = cfg_data_i[15:0];
          afis_pkg::CfgPlaybackRate: rate_q = cfg_data_i;
          afis_pkg::CfgTextureCount: count_q = cfg_data_i[afis_pkg::CountW-1:0];
          afis_pkg::CfgEndMode:      mode_q = afis_pkg::end_mode_e'(cfg_data_i[1:0]);
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_selections.size() == 0) begin
          if (mismatch_count_o < 10) begin
            $display("Unexpected result: index %0d backward %0b with no item pending",
                     texture_index_i, play_backward_i);
          end
          mismatch_count_o++;
        end else begin
          want = expected_selections.pop_front();
          if (texture_index_i !== want.index || play_backward_i !== want.backward) begin
            if (mismatch_count_o < 10) begin
              $display("Mismatch: expected index %0d backward %0b, got index %0d backward %0b",
                       want.index, want.backward, texture_index_i, play_backward_i);
            end
            mismatch_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_selections.push_back(select_texture(frame_time_i));
      end
    end
  end

endmodule

// File: bench/animation_frame_index_select_tb.sv
`timescale 1ns / 100ps
// Top of the animation frame index selector testbench: clock, reset, register settings,
// frame stimulus, output stalls and the verdict. Depends on afis_pkg,
// animation_frame_index_select and frame_index_checker.
module animation_frame_index_select_tb;

  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned HoldOffCycles = 300;

  logic                              clk = 1'b0;
  logic                              rst_n;
  logic                              cfg_we;
  logic [1:0]                        cfg_index;
  logic [afis_pkg::RateW-1:0]        cfg_data;
  logic                              in_valid;
  logic                              in_stall;
  logic signed [31:0]                frame_time;
  logic                              out_valid;
  logic                              out_stall;
  logic [afis_pkg::RawW-1:0]         texture_index;
  logic                              play_backward;
  int unsigned                       mismatches;
  int unsigned                       pending;
  int unsigned                       quiet_cycles = 0;
  bit                                idle_en;
  bit                                hold_req;
  logic [15:0]                       start_now;

  always #5 clk = ~clk;

  animation_frame_index_select dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .frame_time_i    (frame_time),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .texture_index_o (texture_index),
    .play_backward_o (play_backward)
  );

  frame_index_checker checker_i (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .frame_time_i     (frame_time),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .texture_index_i  (texture_index),
    .play_backward_i  (play_backward),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QuietLimit) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    bit held;
    held = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HoldOffCycles) @(negedge clk);
        out_stall <= 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic write_selector_settings(input logic [afis_pkg::RateW-1:0] sf,
                                         input logic [afis_pkg::RateW-1:0] rate,
                                         input logic [afis_pkg::RateW-1:0] cnt,
                                         input logic [afis_pkg::RateW-1:0] mode);
    cfg_we <= 1'b1;
    cfg_index <= afis_pkg::CfgStartFrame;
    cfg_data <= sf;
    @(negedge clk);
    cfg_index <= afis_pkg::CfgPlaybackRate;
    cfg_data <= rate;
    @(negedge clk);
    cfg_index <= afis_pkg::CfgTextureCount;
    cfg_data <= cnt;
    @(negedge clk);
    cfg_index <= afis_pkg::CfgEndMode;
    cfg_data <= mode;
    @(negedge clk);
    cfg_we <= 1'b0;
    start_now = sf[15:0];
  endtask

  task automatic offer_frame(input logic [31:0] ft);
    int unsigned gap;
    if (idle_en && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    frame_time <= ft;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_selections();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_frame();
    longint      base;
    longint      span;
    logic [31:0] ft;
    base = longint'(start_now) << 16;
    case ($urandom_range(0, 7))
      0: ft = $urandom();
      1: ft = {1'b1, 31'($urandom())};
      2: ft = 32'(base + $urandom_range(0, 2) - 1);
      default: begin
        span = longint'($urandom()) >> $urandom_range(4, 26);
        ft = (base + span > 64'sh7fff_ffff) ? ($urandom() >> 1) : 32'(base + span);
      end
    endcase
    return ft;
  endfunction

  task automatic run_random_phase(input int unsigned n_items);
    logic [afis_pkg::RateW-1:0] sf;
    logic [afis_pkg::RateW-1:0] rate;
    logic [afis_pkg::RateW-1:0] cnt;
    logic [1:0]                 mode;
    sf = ($urandom_range(0, 4) == 0) ? 24'($urandom())
                                     : {8'($urandom()), 16'($urandom_range(0, 40))};
    case ($urandom_range(0, 4))
      0: rate = '0;
      1: rate = 24'd65536;
      2: rate = 24'($urandom_range(1, 65535));
      3: rate = 24'($urandom());
      default: rate = 24'($urandom_range(65536, 1 << 20));
    endcase
    case ($urandom_range(0, 5))
      0: cnt = {8'($urandom()), 16'($urandom_range(0, 1))};
      1, 2: cnt = {8'($urandom()), 16'($urandom_range(2, 8))};
      3, 4: cnt = {8'($urandom()), 16'($urandom_range(9, 300))};
      default: cnt = 24'($urandom());
    endcase
    mode = 2'($urandom_range(0, 3));
    write_selector_settings(sf, rate, cnt, {22'($urandom()), mode});
    repeat (n_items) offer_frame(pick_frame());
    drain_selections();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = afis_pkg::CfgStartFrame;
    cfg_data = '0;
    in_valid = 1'b0;
    frame_time = '0;
    idle_en = 1'b1;
    hold_req = 1'b0;
    start_now = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Defaults after reset: a single texture, so every frame gives index 0.
    offer_frame(32'h0000_0000);
    offer_frame(32'h7fff_ffff);
    offer_frame(32'h8000_0000);
    offer_frame(32'hffff_ffff);
    drain_selections();

    // Ping-pong around the start frame, across both directions and the mirror point.
    write_selector_settings(24'd5, 24'd65536, 24'd7, 24'(afis_pkg::ModePingPong));
    offer_frame(32'h0005_0000);
    offer_frame(32'h0005_0001);
    offer_frame(32'h0007_0000);
    offer_frame(32'h000d_0000);
    offer_frame(32'h000e_0000);
    offer_frame(32'h7fff_ffff);
    offer_frame(32'h8000_0000);
    drain_selections();

    // A zero rate turns ping-pong forward.
    write_selector_settings(24'd0, 24'd0, 24'd3, 24'(afis_pkg::ModePingPong));
    offer_frame(32'h0000_03e8);
    offer_frame(32'h7fff_ffff);
    drain_selections();

    // The largest start frame lies beyond every positive frame.
    write_selector_settings(24'hff_ffff, 24'hff_ffff, 24'hff_ffff, 24'(afis_pkg::ModeLoop));
    offer_frame(32'h7fff_ffff);
    offer_frame(32'h8000_0001);
    drain_selections();

    write_selector_settings(24'd1, 24'hff_ffff, 24'd65535, 24'(afis_pkg::ModeHold));
    offer_frame(32'h7fff_ffff);
    offer_frame(32'h0002_0000);
    drain_selections();

    // A texture count of zero behaves like a single texture.
    write_selector_settings(24'd0, 24'd65536, 24'd0, 24'(afis_pkg::ModePass));
    offer_frame(32'h0000_3039);
    drain_selections();

    write_selector_settings(24'd0, 24'h80_0000, 24'd2, 24'(afis_pkg::ModePass));
    offer_frame(32'h7fff_ffff);
    offer_frame(32'h0001_0000);
    drain_selections();

    for (int ph = 0; ph < 13; ph++) begin
      idle_en = (ph % 4 != 1) && (ph < 10);
      if (ph == 2) begin
        hold_req = 1'b1;
      end
      run_random_phase(48);
    end

    if (mismatches == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: animation_frame_index_select.f
hdl/afis_pkg.sv
hdl/afis_ctrl.sv
hdl/afis_datapath.sv
hdl/animation_frame_index_select.sv
bench/frame_index_checker.sv
bench/animation_frame_index_select_tb.sv
